// ===== design/bfpa_pkg.sv =====
// Shared constants, codes and types of the best-fit page allocator.
package bfpa_pkg;
	localparam int MAX_PAGES = 4096;
	localparam int MAX_RUNS  = 64;
	localparam int PAGE_W    = $clog2(MAX_PAGES);
	localparam int LEN_W     = PAGE_W + 1;
	localparam int RIDX_W    = $clog2(MAX_RUNS);
	localparam int RCNT_W    = RIDX_W + 1;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_REINIT = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLEN,
		S_SCAN,
		S_EVAL,
		S_COPY,
		S_INS,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [PAGE_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} run_t;
endpackage

// ===== design/bfpa_req_if.sv =====
// Request channel: command and its operands.
interface bfpa_req_if;
	logic                        valid;
	logic                        ready;
	logic [bfpa_pkg::CMD_W-1:0]  command;
	logic [bfpa_pkg::PAGE_W-1:0] page_count;
	logic [bfpa_pkg::PAGE_W-1:0] block_page;

	modport source (output valid, command, page_count, block_page, input ready);
	modport sink (input valid, command, page_count, block_page, output ready);
endinterface

// ===== design/bfpa_rsp_if.sv =====
// Response channel: status, granted page and run size.
interface bfpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bfpa_pkg::STAT_W-1:0] status;
	logic [bfpa_pkg::PAGE_W-1:0] granted_page;
	logic [bfpa_pkg::LEN_W-1:0]  run_pages;

	modport source (output valid, status, granted_page, run_pages, input ready);
	modport sink (input valid, status, granted_page, run_pages, output ready);
endinterface

// ===== design/bfpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module bfpa_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/best_fit_page_allocator.sv =====
// Best-fit page allocator: top level with sequencer, free-run table and length store.
//
// Channels: req (command, page_count, block_page) and rsp (status, granted_page,
// run_pages), both valid/ready; a transaction moves on an edge with both high.
// Write total_pages through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. One command at a time: req.ready is high
// only in the idle state. Allocate scans every table entry for the smallest run
// that fits, then answers; when that run is used up exactly, the later entries
// are shifted down to close the gap. Free reads the stored length of the block,
// then scans the table; a merge of both neighbors shifts later entries down, and
// an insert shifts them up to open a slot. Reinitialize, unused commands and a
// bad block page answer without a scan, and a bad stored length answers after
// the length read, also without a scan. The table is read one entry per cycle
// through its single read port.
// The response sits in an output register; the next command is accepted
// while it waits, and the sequencer holds its next result until rsp is free.
// Reset: total_pages is 4096 and the table holds one run of 4096 pages at
// page 0. Table entry 0 is covered by a register until first written, so no
// clearing pass is needed. The length store is not cleared.
module best_fit_page_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	bfpa_req_if.sink                    req,
	bfpa_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [bfpa_pkg::LEN_W-1:0]  cfg_wdata
);
	import bfpa_pkg::*;

	state_t state_q, nxt;

	logic [LEN_W-1:0]  tot_q;
	logic [LEN_W-1:0]  lim;
	logic [RCNT_W-1:0] cnt_q;
	logic              e0_v_q;
	logic [LEN_W-1:0]  e0_len_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [LEN_W-1:0]  need_q;
	logic [PAGE_W-1:0] h_q;
	logic [LEN_W-1:0]  len_q;

	logic [RCNT_W-1:0] idx_q;
	logic              pend_q;
	logic [RIDX_W-1:0] pidx_q;
	logic              ovr_q;
	logic              issue;

	logic              found_q;
	logic [RIDX_W-1:0] best_idx_q;
	logic [PAGE_W-1:0] best_s_q;
	logic [LEN_W-1:0]  best_l_q;
	logic [RCNT_W-1:0] pos_q;
	logic [PAGE_W-1:0] prev_s_q;
	logic [LEN_W-1:0]  prev_l_q;
	logic              aft_v_q;
	logic [PAGE_W-1:0] aft_s_q;
	logic [LEN_W-1:0]  aft_l_q;

	logic [RCNT_W-1:0] rp_q;
	logic [RCNT_W-1:0] rem_q;
	logic              cp_v_q;
	logic [RIDX_W-1:0] ctgt_q;
	logic              dir_q;
	logic              ins_q;

	logic              ov_q;
	logic [STAT_W-1:0] o_st_q;
	logic [PAGE_W-1:0] o_gp_q;
	logic [LEN_W-1:0]  o_rp_q;
	logic [STAT_W-1:0] r_st_q;
	logic [PAGE_W-1:0] r_gp_q;
	logic [LEN_W-1:0]  r_rp_q;

	// table and store ports
	logic              t_we;
	logic [RIDX_W-1:0] t_waddr, t_raddr;
	run_t              t_wdata, t_rdata, ent;
	logic              s_we;
	logic [PAGE_W-1:0] s_waddr, s_raddr;
	logic [LEN_W-1:0]  s_wdata, s_rdata;

	// sequencer side effects
	logic              res_ld;
	logic [STAT_W-1:0] res_st;
	logic [PAGE_W-1:0] res_gp;
	logic [LEN_W-1:0]  res_rp;
	logic              cnt_ld, e0_ld, cp_ld;
	logic [RCNT_W-1:0] cnt_d, rp_d, rem_d;
	logic              dir_d, ins_d;

	logic [PAGE_W-1:0] h_in;
	logic [LEN_W:0]    hl_in, hl, prev_end;
	logic              ml, mr, fbad;

	bfpa_ram #(.W($bits(run_t)), .D(MAX_RUNS)) u_tbl (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	bfpa_ram #(.W(LEN_W), .D(MAX_PAGES)) u_store (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	assign lim = (tot_q > LEN_W'(MAX_PAGES)) ? LEN_W'(MAX_PAGES) : tot_q;
	assign h_in = req.block_page - PAGE_W'(1);
	assign hl_in = {1'b0, h_q} + {1'b0, s_rdata};
	assign hl = {1'b0, h_q} + {1'b0, len_q};
	assign prev_end = {1'b0, prev_s_q} + {1'b0, prev_l_q};
	assign ml = (pos_q != '0) && (prev_end == (LEN_W+1)'(h_q));
	assign mr = aft_v_q && (hl == (LEN_W+1)'(aft_s_q));
	assign fbad = ((pos_q != '0) && (prev_end > (LEN_W+1)'(h_q))) ||
		(aft_v_q && ((LEN_W+1)'(aft_s_q) < hl));
	assign issue = (idx_q < cnt_q);
	// entry 0 reads from its register until first written
	assign ent = ovr_q ? run_t'{start: '0, len: e0_len_q} : t_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.status = o_st_q;
	assign rsp.granted_page = o_gp_q;
	assign rsp.run_pages = o_rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt = state_q;
		t_we = 1'b0;
		t_waddr = '0;
		t_wdata = '0;
		t_raddr = idx_q[RIDX_W-1:0];
		s_we = 1'b0;
		s_waddr = h_q;
		s_wdata = '0;
		s_raddr = h_in;
		res_ld = 1'b0;
		res_st = ST_OK;
		res_gp = '0;
		res_rp = '0;
		cnt_ld = 1'b0;
		cnt_d = cnt_q;
		e0_ld = 1'b0;
		cp_ld = 1'b0;
		rp_d = '0;
		rem_d = '0;
		dir_d = 1'b0;
		ins_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.command)
						CMD_ALLOC: nxt = S_SCAN;
						CMD_FREE: begin
							if (req.block_page == '0 || {1'b0, h_in} >= lim) begin
								res_ld = 1'b1;
								res_st = ST_BAD;
								nxt = S_RESP;
							end else begin
								nxt = S_FLEN;
							end
						end
						CMD_REINIT: begin
							res_ld = 1'b1;
							res_rp = lim;
							cnt_ld = 1'b1;
							cnt_d = (lim != '0) ? RCNT_W'(1) : '0;
							e0_ld = 1'b1;
							nxt = S_RESP;
						end
						default: begin
							res_ld = 1'b1;
							nxt = S_RESP;
						end
					endcase
				end
			end
			S_FLEN: begin
				if (s_rdata == '0 || hl_in > (LEN_W+1)'(lim)) begin
					res_ld = 1'b1;
					res_st = ST_BAD;
					nxt = S_RESP;
				end else begin
					nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!issue && !pend_q) begin
					nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				res_ld = 1'b1;
				nxt = S_RESP;
				if (cmd_q == CMD_ALLOC) begin
					if (!found_q) begin
						res_st = ST_OOM;
					end else begin
						res_gp = best_s_q + PAGE_W'(1);
						res_rp = need_q;
						s_we = 1'b1;
						s_waddr = best_s_q;
						s_wdata = need_q;
						if (best_l_q > need_q) begin
							t_we = 1'b1;
							t_waddr = best_idx_q;
							t_wdata.start = best_s_q + need_q[PAGE_W-1:0];
							t_wdata.len = best_l_q - need_q;
						end else begin
							// run used up: close the gap
							cnt_ld = 1'b1;
							cnt_d = cnt_q - RCNT_W'(1);
							cp_ld = 1'b1;
							rp_d = RCNT_W'(best_idx_q) + RCNT_W'(1);
							rem_d = cnt_q - RCNT_W'(1) - RCNT_W'(best_idx_q);
							nxt = S_COPY;
						end
					end
				end else if (fbad) begin
					res_st = ST_BAD;
				end else if (!ml && !mr && cnt_q == RCNT_W'(MAX_RUNS)) begin
					res_st = ST_FULL;
				end else begin
					res_rp = len_q;
					s_we = 1'b1;
					s_wdata = '0;
					if (ml) begin
						t_we = 1'b1;
						t_waddr = RIDX_W'(pos_q - RCNT_W'(1));
						t_wdata.start = prev_s_q;
						t_wdata.len = mr ? prev_l_q + len_q + aft_l_q : prev_l_q + len_q;
						if (mr) begin
							cnt_ld = 1'b1;
							cnt_d = cnt_q - RCNT_W'(1);
							cp_ld = 1'b1;
							rp_d = pos_q + RCNT_W'(1);
							rem_d = cnt_q - RCNT_W'(1) - pos_q;
							nxt = S_COPY;
						end
					end else if (mr) begin
						t_we = 1'b1;
						t_waddr = pos_q[RIDX_W-1:0];
						t_wdata.start = h_q;
						t_wdata.len = aft_l_q + len_q;
					end else begin
						// open a slot at pos, then insert
						cnt_ld = 1'b1;
						cnt_d = cnt_q + RCNT_W'(1);
						cp_ld = 1'b1;
						rp_d = cnt_q - RCNT_W'(1);
						rem_d = cnt_q - pos_q;
						dir_d = 1'b1;
						ins_d = 1'b1;
						nxt = S_COPY;
					end
				end
			end
			S_COPY: begin
				t_raddr = rp_q[RIDX_W-1:0];
				if (cp_v_q) begin
					t_we = 1'b1;
					t_waddr = ctgt_q;
					t_wdata = ent;
				end
				if (rem_q == '0 && !cp_v_q) begin
					nxt = ins_q ? S_INS : S_RESP;
				end
			end
			S_INS: begin
				t_we = 1'b1;
				t_waddr = pos_q[RIDX_W-1:0];
				t_wdata.start = h_q;
				t_wdata.len = len_q;
				nxt = S_RESP;
			end
			S_RESP: begin
				if (!ov_q || rsp.ready) begin
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= LEN_W'(MAX_PAGES);
			cnt_q <= RCNT_W'(1);
			e0_v_q <= 1'b1;
			e0_len_q <= LEN_W'(MAX_PAGES);
			ov_q <= 1'b0;
			idx_q <= '0;
			pend_q <= 1'b0;
			ovr_q <= 1'b0;
			rem_q <= '0;
			cp_v_q <= 1'b0;
			ins_q <= 1'b0;
			dir_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tot_q <= cfg_wdata;
			end
			if (cnt_ld) begin
				cnt_q <= cnt_d;
			end
			if (e0_ld) begin
				e0_v_q <= 1'b1;
				e0_len_q <= lim;
			end else if (t_we && t_waddr == '0) begin
				e0_v_q <= 1'b0;
			end
			ovr_q <= (t_raddr == '0) && e0_v_q && !(t_we && t_waddr == '0);
			if (state_q == S_RESP && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				idx_q <= issue ? idx_q + RCNT_W'(1) : idx_q;
				pend_q <= issue;
			end else begin
				idx_q <= '0;
				pend_q <= 1'b0;
			end
			if (cp_ld) begin
				rem_q <= rem_d;
				dir_q <= dir_d;
				ins_q <= ins_d;
				cp_v_q <= 1'b0;
			end else if (state_q == S_COPY) begin
				cp_v_q <= (rem_q != '0);
				if (rem_q != '0) begin
					rem_q <= rem_q - RCNT_W'(1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q <= req.command;
			need_q <= {1'b0, req.page_count} + LEN_W'(1);
			h_q <= h_in;
			found_q <= 1'b0;
			pos_q <= '0;
			aft_v_q <= 1'b0;
		end
		if (state_q == S_FLEN) begin
			len_q <= s_rdata;
		end
		if (state_q == S_SCAN) begin
			pidx_q <= idx_q[RIDX_W-1:0];
			if (pend_q) begin
				if (cmd_q == CMD_ALLOC) begin
					if (ent.len >= need_q && (!found_q || ent.len < best_l_q)) begin
						found_q <= 1'b1;
						best_idx_q <= pidx_q;
						best_s_q <= ent.start;
						best_l_q <= ent.len;
					end
				end else if (ent.start < h_q) begin
					pos_q <= pos_q + RCNT_W'(1);
					prev_s_q <= ent.start;
					prev_l_q <= ent.len;
				end else if (!aft_v_q) begin
					aft_v_q <= 1'b1;
					aft_s_q <= ent.start;
					aft_l_q <= ent.len;
				end
			end
		end
		if (cp_ld) begin
			rp_q <= rp_d;
		end else if (state_q == S_COPY && rem_q != '0) begin
			rp_q <= dir_q ? rp_q - RCNT_W'(1) : rp_q + RCNT_W'(1);
			ctgt_q <= dir_q ? RIDX_W'(rp_q + RCNT_W'(1)) : RIDX_W'(rp_q - RCNT_W'(1));
		end
		if (res_ld) begin
			r_st_q <= res_st;
			r_gp_q <= res_gp;
			r_rp_q <= res_rp;
		end
		if (state_q == S_RESP && (!ov_q || rsp.ready)) begin
			o_st_q <= r_st_q;
			o_gp_q <= r_gp_q;
			o_rp_q <= r_rp_q;
		end
	end
endmodule

// ===== design/bfpa_chk.sv =====
// Port-level checker for the best-fit page allocator, bound to the top level.
module bfpa_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [bfpa_pkg::STAT_W-1:0] rsp_status,
	input logic [bfpa_pkg::PAGE_W-1:0] rsp_granted_page,
	input logic [bfpa_pkg::LEN_W-1:0]  rsp_run_pages
);
	import bfpa_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a command was in progress");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
		rsp_granted_page == '0 && rsp_run_pages == '0)
		else $error("error response carries nonzero payload");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_granted_page) && $stable(rsp_run_pages))
		else $error("stalled response changed");
endmodule

bind best_fit_page_allocator bfpa_chk u_bfpa_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_granted_page(rsp.granted_page),
	.rsp_run_pages(rsp.run_pages)
);
